### hw/rtl/cilp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cilp_pkg
// Shared widths and character codes for the integer literal parser.
// ----------------------------------------------------------------------------
package cilp_pkg;

  localparam int unsigned CHAR_W = 8;

  typedef logic [CHAR_W-1:0] char_t;

  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_MINUS = 8'h2d;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_SEVEN = 8'h37;
  localparam char_t CH_NINE  = 8'h39;
  localparam char_t CH_UP_A  = 8'h41;
  localparam char_t CH_UP_F  = 8'h46;
  localparam char_t CH_LO_A  = 8'h61;
  localparam char_t CH_LO_F  = 8'h66;
  localparam char_t CH_LO_X  = 8'h78;
  localparam char_t CH_TILDE = 8'h7e;

endpackage : cilp_pkg
`default_nettype wire

### hw/rtl/cilp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cilp_if
// Valid/ready channels: one for characters in, one for parsed values out.
// ----------------------------------------------------------------------------
interface cilp_char_if
  import cilp_pkg::*;
();
  logic  valid;
  logic  ready;
  char_t ch;
  logic  last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface : cilp_char_if

interface cilp_value_if #(
  parameter int unsigned VALUE_WIDTH = 64
) ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface : cilp_value_if
`default_nettype wire

### hw/rtl/c_style_integer_literal_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c_style_integer_literal_parser
// Streams a C-style decimal, octal or hex literal one character per item.
// ----------------------------------------------------------------------------
// usage:
//   in_i  carries one character per item with a flag on the final character
//   res_o carries one parsed value per string, sent after its last character
//   leading blanks are skipped, a leading 0 selects octal and 0x hex; octal
//   and hex take a ~ (invert), decimal takes a - (negate); the first
//   character not accepted ends the number and later ones are ignored
// path: a last character passes the input register and then the result
//   register, from which its value is shown on res_o
// throughput: one character per cycle unless a last character waits on a
//   stalled res_o; the parse state is updated by a single shift-add on the
//   accumulator per character; a new item is taken while a finished value
//   waits on res_o; only a last character is held in the input register while res_o stalls
// reset: parser returns to its start state, both registers are emptied
// ----------------------------------------------------------------------------
module c_style_integer_literal_parser
  import cilp_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  cilp_char_if.sink    in_i,
  cilp_value_if.source res_o
);

  localparam int unsigned W = VALUE_WIDTH;

  typedef enum logic [2:0] {
    M_START,
    M_OCT_START,
    M_HEX_START,
    M_DEC,
    M_OCT,
    M_HEX,
    M_DONE
  } mode_e;

  typedef enum logic [1:0] {
    S_NONE,
    S_NEG,
    S_INV
  } sign_e;

  typedef enum logic [1:0] {
    B_DEC,
    B_OCT,
    B_HEX
  } base_e;

  // input register
  logic  s1_valid_q, s1_valid_d;
  char_t s1_ch_q;
  logic  s1_last_q;
  logic  s1_adv;

  // parse state
  mode_e          mode_q, mode_d;
  sign_e          sign_q, sign_d;
  logic [W-1:0]   acc_q, acc_d;

  // result register
  logic           out_valid_q, out_valid_d;
  logic [W-1:0]   value_q, value_d;

  // character decode
  logic           blank, is_num, is_lo, is_up, dig_ok;
  logic [3:0]     dig;
  base_e          base;
  logic [W-1:0]   acc_scaled, dig_ext, acc_step;

  assign s1_adv      = s1_valid_q && (!s1_last_q || !out_valid_q || res_o.ready);
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign s1_valid_d  = (in_i.valid && in_i.ready) || (s1_valid_q && !s1_adv);

  assign res_o.valid = out_valid_q;
  assign res_o.value = value_q;

  always_comb begin
    blank  = (s1_ch_q == CH_SPACE) || (s1_ch_q == CH_TAB);
    is_num = s1_ch_q inside {[CH_ZERO:CH_NINE]};
    is_lo  = s1_ch_q inside {[CH_LO_A:CH_LO_F]};
    is_up  = s1_ch_q inside {[CH_UP_A:CH_UP_F]};
    if (is_num) begin
      dig = s1_ch_q[3:0];
    end else begin
      // letters a-f / A-F share the low nibble 1..6
      dig = s1_ch_q[3:0] + 4'd9;
    end

    case (mode_q)
      M_OCT_START, M_OCT: base = B_OCT;
      M_HEX_START, M_HEX: base = B_HEX;
      default:            base = B_DEC;
    endcase

    case (base)
      B_OCT:   begin
        dig_ok     = is_num && (s1_ch_q <= CH_SEVEN);
        acc_scaled = acc_q << 3;
      end
      B_HEX:   begin
        dig_ok     = is_num || is_lo || is_up;
        acc_scaled = acc_q << 4;
      end
      default: begin
        dig_ok     = is_num;
        acc_scaled = (acc_q << 3) + (acc_q << 1);
      end
    endcase

    // a negative literal accumulates its negation directly: -(10a+d) = 10(-a)-d
    dig_ext = {{(W-4){1'b0}}, dig};
    if (sign_q == S_NEG) begin
      acc_step = acc_scaled - dig_ext;
    end else begin
      acc_step = acc_scaled + dig_ext;
    end
  end

  always_comb begin
    mode_d = mode_q;
    sign_d = sign_q;
    acc_d  = acc_q;

    case (mode_q)
      M_START: begin
        if (!blank) begin
          if (s1_ch_q == CH_ZERO) begin
            mode_d = M_OCT_START;
          end else if (s1_ch_q == CH_MINUS) begin
            sign_d = S_NEG;
            mode_d = M_DEC;
          end else if (dig_ok) begin
            acc_d  = acc_step;
            mode_d = M_DEC;
          end else begin
            mode_d = M_DONE;
          end
        end
      end
      M_OCT_START: begin
        if (!blank) begin
          if (s1_ch_q == CH_LO_X) begin
            mode_d = M_HEX_START;
          end else if (s1_ch_q == CH_TILDE) begin
            sign_d = S_INV;
            mode_d = M_OCT;
          end else if (dig_ok) begin
            acc_d  = acc_step;
            mode_d = M_OCT;
          end else begin
            mode_d = M_DONE;
          end
        end
      end
      M_HEX_START: begin
        if (!blank) begin
          if (s1_ch_q == CH_TILDE) begin
            sign_d = S_INV;
            mode_d = M_HEX;
          end else if (dig_ok) begin
            acc_d  = acc_step;
            mode_d = M_HEX;
          end else begin
            mode_d = M_DONE;
          end
        end
      end
      M_DEC, M_OCT, M_HEX: begin
        if (dig_ok) begin
          acc_d = acc_step;
        end else begin
          mode_d = M_DONE;
        end
      end
      default: begin
      end
    endcase

    if (sign_d == S_INV) begin
      value_d = ~acc_d;
    end else begin
      value_d = acc_d;
    end

    out_valid_d = out_valid_q && !res_o.ready;
    if (s1_adv && s1_last_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= M_START;
      sign_q      <= S_NONE;
      acc_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        if (s1_last_q) begin
          mode_q <= M_START;
          sign_q <= S_NONE;
          acc_q  <= '0;
        end else begin
          mode_q <= mode_d;
          sign_q <= sign_d;
          acc_q  <= acc_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_ch_q   <= in_i.ch;
      s1_last_q <= in_i.last;
    end
    if (s1_adv && s1_last_q) begin
      value_q <= value_d;
    end
  end

  // negate only reachable through the decimal path
  a_neg_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sign_q == S_NEG |-> (mode_q == M_DEC || mode_q == M_DONE))
    else $error("negate sign outside decimal mode");

  a_inv_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sign_q == S_INV |-> (mode_q == M_OCT || mode_q == M_HEX || mode_q == M_DONE))
    else $error("invert sign outside octal or hex mode");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> out_valid_q)
    else $error("last character did not produce a value");

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> (mode_q == M_START && sign_q == S_NONE && acc_q == '0))
    else $error("parser not back at start after last character");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |-> (s1_last_q && out_valid_q && !res_o.ready))
    else $error("input register held without a stalled result");

endmodule : c_style_integer_literal_parser
`default_nettype wire
